/* sv/rpsc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the rod position and scram controller.
// No dependencies; imported by the controller and its checker.
package rpsc_pkg;

    // Field widths
    localparam int TEMP_W   = 12;
    localparam int DEMAND_W = 10;
    localparam int DEPTH_W  = 7;
    localparam int HOLD_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Rod depth when fully inserted
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = 7'd100;

    // Reset values of the settings and the state
    localparam logic [TEMP_W-1:0]  HIGH_TEMP_RST = 12'd800;
    localparam logic [TEMP_W-1:0]  MARGIN_RST    = 12'd50;
    localparam logic [TEMP_W-1:0]  RISE_RST      = 12'd25;
    localparam logic [HOLD_W-1:0]  HOLD_RST      = 4'd3;
    localparam logic [DEPTH_W-1:0] MAX_STEP_RST  = 7'd10;
    localparam logic [TEMP_W-1:0]  PREV_TEMP_RST = 12'd750;

    // Division by ten as a multiply by 205 and a shift by 11; exact for 0..1023
    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;

    // Settings register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_TEMP = 3'd0,
        REG_MARGIN    = 3'd1,
        REG_RISE      = 3'd2,
        REG_HOLD      = 3'd3,
        REG_MAX_STEP  = 3'd4
    } cfg_reg_t;

    // Control mode reported with each result item
    typedef enum logic [1:0] {
        MODE_SCRAM  = 2'd0,
        MODE_RISE   = 2'd1,
        MODE_DEMAND = 2'd2
    } mode_t;

endpackage

/* sv/rod_position_scram_controller.sv */
`timescale 1ns / 1ps
// Rod position and scram controller: one sensor item in, one rod command out.
// Depends on rpsc_pkg.
//
// Usage:
//  - s_ channel carries one sensor item per control tick: temperature and
//    demand in s_tdata, the seismic flag in s_tuser.
//  - m_ channel returns one result item per sensor item: the new rod depth in
//    m_tdata, the scram latch and the control mode in m_tuser.
//  - cfg_ channel writes the five settings by index; it is always ready and
//    should only be used while no item is in flight. Indexes of 5 and above
//    are ignored.
//  - The path has two register stages: the item sits in the input
//    register, then the control logic loads the result register, where the
//    rod, latch, hold and previous-temperature state update at the same edge.
//  - Throughput is one item per cycle while the receiver does not stall; the
//    state loop closes through one stage of compares, adds and a constant multiply.
//  - When the receiver stalls, the result waits in the output register and one
//    more item is held in the input register, after which s_tready drops.
//  - Reset (aresetn low, synchronous) empties both registers, inserts the
//    rods fully, clears the latch and hold count, sets the previous
//    temperature to 750 and restores the default settings.
module rod_position_scram_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Sensor items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [11:0] temperature, [21:12] demand_mw, [23:22] zero
    input  logic [0:0]  s_tuser,   // [0] seismic
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] depth, [7] zero
    output logic [2:0]  m_tuser,   // [0] scram, [2:1] mode
    // Settings writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpsc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rpsc_pkg::*;

    // Settings
    logic [TEMP_W-1:0]  high_temp_reg;
    logic [TEMP_W-1:0]  margin_reg;
    logic [TEMP_W-1:0]  rise_reg;
    logic [HOLD_W-1:0]  hold_ticks_reg;
    logic [DEPTH_W-1:0] max_step_reg;

    // Control state
    logic [DEPTH_W-1:0] rod_depth_reg;
    logic [TEMP_W-1:0]  prev_temp_reg;
    logic               latch_reg;
    logic [HOLD_W-1:0]  hold_reg;

    // Input register
    logic                in_valid_reg;
    logic [TEMP_W-1:0]   in_temp_reg;
    logic                in_seismic_reg;
    logic [DEMAND_W-1:0] in_demand_reg;

    // Result register
    logic               out_valid_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    logic               out_scram_reg;
    mode_t              out_mode_reg;

    // Next values
    logic [DEPTH_W-1:0] depth_next;
    logic               latch_next;
    logic [HOLD_W-1:0]  hold_next;
    mode_t              mode_next;

    logic advance;
    logic trigger;
    logic latched;
    logic [HOLD_W-1:0] hold_loaded;
    logic [HOLD_W-1:0] hold_dec;
    logic below_release;
    logic rise_fast;
    logic [17:0] demand_prod;
    logic [DEPTH_W-1:0] demand_tenth;
    logic signed [8:0] target;
    logic signed [8:0] rod_up;
    logic signed [8:0] rod_down;
    logic signed [8:0] demand_depth;
    logic [7:0] rise_depth;

    // Handshakes: the logic stage advances whenever it holds an item and the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Settings writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_temp_reg  <= HIGH_TEMP_RST;
            margin_reg     <= MARGIN_RST;
            rise_reg       <= RISE_RST;
            hold_ticks_reg <= HOLD_RST;
            max_step_reg   <= MAX_STEP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HIGH_TEMP: high_temp_reg  <= cfg_data;
                REG_MARGIN:    margin_reg     <= cfg_data;
                REG_RISE:      rise_reg       <= cfg_data;
                REG_HOLD:      hold_ticks_reg <= cfg_data[HOLD_W-1:0];
                REG_MAX_STEP:  max_step_reg   <= cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_temp_reg    <= s_tdata[11:0];
            in_demand_reg  <= s_tdata[21:12];
            in_seismic_reg <= s_tuser[0];
        end
    end

    // Scram latch and hold counter
    always_comb begin
        trigger     = in_seismic_reg || (in_temp_reg >= high_temp_reg);
        latched     = latch_reg || trigger;
        hold_loaded = trigger ? hold_ticks_reg : hold_reg;
        hold_dec    = (hold_loaded == '0) ? '0 : hold_loaded - HOLD_W'(1);
        // Release level may be negative, in which case no temperature is below it
        below_release = ({1'b0, in_temp_reg} + {1'b0, margin_reg}) < {1'b0, high_temp_reg};
    end

    // Rise detection and demand target
    always_comb begin
        rise_fast    = {1'b0, in_temp_reg} > ({1'b0, prev_temp_reg} + {1'b0, rise_reg});
        demand_prod  = {8'b0, in_demand_reg} * {10'b0, DIV10_MUL};
        demand_tenth = demand_prod[17:DIV10_SHIFT];
        target       = $signed({2'b00, DEPTH_FULL}) - $signed({2'b00, demand_tenth});
        rod_up       = $signed({2'b00, rod_depth_reg}) + $signed({2'b00, max_step_reg});
        rod_down     = $signed({2'b00, rod_depth_reg}) - $signed({2'b00, max_step_reg});
        rise_depth   = rod_up[7:0];
    end

    // Depth, mode and next state for the item in the input register
    always_comb begin
        latch_next = latch_reg;
        hold_next  = hold_reg;
        depth_next = DEPTH_FULL;
        mode_next  = MODE_SCRAM;
        demand_depth = target;
        if (latched) begin
            hold_next  = hold_dec;
            latch_next = !((hold_dec == '0) && below_release && !in_seismic_reg);
        end else if (rise_fast) begin
            mode_next  = MODE_RISE;
            depth_next = (rise_depth > {1'b0, DEPTH_FULL}) ? DEPTH_FULL
                                                          : rise_depth[DEPTH_W-1:0];
        end else begin
            mode_next = MODE_DEMAND;
            if (target > rod_up) begin
                demand_depth = rod_up;
            end else if (target < rod_down) begin
                demand_depth = rod_down;
            end
            if (demand_depth < 9'sd0) begin
                depth_next = '0;
            end else if (demand_depth > $signed({2'b00, DEPTH_FULL})) begin
                depth_next = DEPTH_FULL;
            end else begin
                depth_next = demand_depth[DEPTH_W-1:0];
            end
        end
    end

    // Control state updates as each item passes into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rod_depth_reg <= DEPTH_FULL;
            prev_temp_reg <= PREV_TEMP_RST;
            latch_reg     <= 1'b0;
            hold_reg      <= '0;
        end else if (advance) begin
            rod_depth_reg <= depth_next;
            prev_temp_reg <= in_temp_reg;
            latch_reg     <= latch_next;
            hold_reg      <= hold_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_depth_reg <= depth_next;
            out_scram_reg <= latch_next;
            out_mode_reg  <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_depth_reg};
    assign m_tuser  = {out_mode_reg, out_scram_reg};

endmodule

/* sv/rpsc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the rod position and scram controller, bound to it.
// Depends on rpsc_pkg and rod_position_scram_controller.
module rpsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [2:0]  m_tuser
);
    import rpsc_pkg::*;

    // The rod depth never leaves the range 0..100
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= DEPTH_FULL) && !m_tdata[7])
        else $error("rod depth out of range");

    // A latch still set after the tick means the tick ran as a scram override
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == MODE_SCRAM))
        else $error("scram latched outside scram mode");

    // A scram override always drives the rods fully in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[2:1] == MODE_SCRAM)) |-> (m_tdata[6:0] == DEPTH_FULL))
        else $error("scram override without full insertion");

    // Only the three defined modes are reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[2:1] != 2'd3))
        else $error("undefined mode reported");

    // A stalled result item stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

endmodule

bind rod_position_scram_controller rpsc_checker u_rpsc_checker (.*);
